>>> src/ring_window_mean_stddev_defines.svh
// assertion macros for the moving window statistics block
// needs nothing else; included by the checker file
`ifndef RING_WINDOW_MEAN_STDDEV_DEFINES_SVH
`define RING_WINDOW_MEAN_STDDEV_DEFINES_SVH

// same-cycle implication
`define RWMS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RWMS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/rwms_pkg.sv
// shared widths, constants and types of the moving window statistics block
// no dependencies; used by the interfaces, rwms_store, the top level and the checker
package rwms_pkg;

   localparam int DEPTH    = 256;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int SAMPLE_W = 16;
   localparam int LEN_W    = 9;
   localparam int FRAC_W   = 8;
   localparam int OUT_W    = 24;
   localparam int SLOT_W   = 8;

   localparam int SUM_W    = 24;
   localparam int SQSUM_W  = 40;
   localparam int SQ_W     = 2 * SAMPLE_W;
   localparam int PROD_W   = LEN_W + SQSUM_W;
   localparam int SUMSQ_W  = 2 * SUM_W;
   localparam int DEN_W    = 16;
   localparam int MQ_W     = SUM_W + FRAC_W;
   localparam int RT_W     = OUT_W;
   localparam int VQ_W     = 2 * RT_W;
   localparam int VSPLIT   = VQ_W - 2 * FRAC_W;
   localparam int DIV_STEP = 4;

   localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;
   localparam logic [LEN_W-1:0] LEN_MIN   = 9'd2;
   localparam logic [LEN_W-1:0] LEN_MAX   = 9'd256;

   typedef struct packed {
      logic              clear;
      logic              write;
      logic [ADDR_W-1:0] addr;
   } rwms_store_cmd_type;

endpackage

>>> src/rwms_req_bus.sv
// request and response channel interfaces of the moving window statistics block
// depends on rwms_pkg
interface rwms_req_bus;
   import rwms_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface rwms_rsp_bus;
   import rwms_pkg::*;

   logic              valid;
   logic              ready;
   logic [OUT_W-1:0]  mean_fix;
   logic [OUT_W-1:0]  stddev_fix;
   logic [SLOT_W-1:0] slot_written;

   modport source (output valid, output mean_fix, output stddev_fix, output slot_written,
                   input ready);
   modport sink (input valid, input mean_fix, input stddev_fix, input slot_written,
                 output ready);
endinterface

>>> src/rwms_store.sv
// sample ring memory with per-entry valid bits, read-first, registered read data
// depends on rwms_pkg
module rwms_store (
   input  logic                               clock,
   input  logic                               reset,
   input  rwms_pkg::rwms_store_cmd_type       cmd,
   input  logic signed [rwms_pkg::SAMPLE_W-1:0] wr_data,
   output logic signed [rwms_pkg::SAMPLE_W-1:0] rd_data
);
   import rwms_pkg::*;

   logic signed [SAMPLE_W-1:0] mem_ff [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic [DEPTH-1:0]           valid_ff;
   logic                       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         rd_data_ff        <= mem_ff[cmd.addr];
         mem_ff[cmd.addr]  <= wr_data;
      end
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else if (cmd.write) begin
         rd_valid_ff        <= valid_ff[cmd.addr];
         valid_ff[cmd.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> src/rwms_div.sv
// serial restoring divider, STEP_BITS quotient bits per cycle
// depends on nothing; used for the mean and the variance quotient
module rwms_div #(
   parameter int DVS_W     = 16,
   parameter int Q_W       = 48,
   parameter int STEP_BITS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVS_W-1:0] rem_init,
   input  logic [Q_W-1:0]   dividend_lo,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [Q_W-1:0]   quotient
);
   localparam int STEPS = Q_W / STEP_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   shift_ff, shift_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;

   // dividend bits leave at the top, quotient bits enter at the bottom
   always_comb begin
      logic [DVS_W:0] trial;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      trial    = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial    = {rem_in, shift_in[Q_W-1]};
         shift_in = {shift_in[Q_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial       = trial - {1'b0, dvs_ff};
            shift_in[0] = 1'b1;
         end
         rem_in = trial[DVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(STEPS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= rem_init;
         shift_ff <= dividend_lo;
         dvs_ff   <= divisor;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         shift_ff <= shift_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = shift_ff;

endmodule

>>> src/rwms_isqrt.sv
// serial integer square root, one root bit per cycle, floor result
// depends on nothing
module rwms_isqrt #(
   parameter int RT_W = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2*RT_W-1:0] radicand,
   output logic              busy,
   output logic [RT_W-1:0]   root
);
   localparam int CNT_W = $clog2(RT_W + 1);

   logic [RT_W+1:0]   rem_ff, rem_in;
   logic [RT_W-1:0]   root_ff, root_in;
   logic [2*RT_W-1:0] rad_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic [RT_W+1:0]   rem_sh;
   logic [RT_W+1:0]   trial;

   assign rem_sh = {rem_ff[RT_W-1:0], rad_ff[2*RT_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   always_comb begin
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[RT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_ff[RT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(RT_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         root_ff <= '0;
         rad_ff  <= radicand;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= {rad_ff[2*RT_W-3:0], 2'b00};
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

>>> src/ring_window_mean_stddev.sv
// Moving window mean and sample standard deviation over a ring of samples.
// req_bus carries one signed sample per word; the sample replaces the oldest
// ring entry and the block answers with one rsp_bus word: the window mean and
// the sample standard deviation (divisor n-1), both with 8 fraction bits and
// truncated, plus the ring slot that was written.
// csr_we/csr_wdata set the window length n (taken into 2..256); every write
// also empties the ring and the running sums. Write it only while idle.
// A request runs through the memory read-modify-write, the sum updates, the
// products and the numerator, the variance divider (4 quotient bits at a time,
// with the mean divider running alongside) and the square root unit (one root
// bit at a time); no new request is taken until its result is loaded for output.
// Reset empties the ring (all entries read as zero), sets n to 256 and
// clears the write position and sums; no clearing pass is needed.
// A stalled response waits in the output register; the next request is
// still accepted and computed, and only its result waits for the register.
// depends on rwms_pkg, rwms_req_bus, rwms_rsp_bus, rwms_store, rwms_div, rwms_isqrt
module ring_window_mean_stddev (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [rwms_pkg::LEN_W-1:0] csr_wdata,
   rwms_req_bus.sink                  req_bus,
   rwms_rsp_bus.source                rsp_bus
);
   import rwms_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_UPD1 = 8'b0000_0010,
      ST_UPD2 = 8'b0000_0100,
      ST_MUL  = 8'b0000_1000,
      ST_SUB  = 8'b0001_0000,
      ST_DIV  = 8'b0010_0000,
      ST_ROOT = 8'b0100_0000,
      ST_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] wpos_ff;
   logic [ADDR_W-1:0] pos;
   logic [ADDR_W-1:0] wpos_next;
   logic              accept;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic [ADDR_W-1:0]          pos_ff;
   logic signed [SAMPLE_W-1:0] old_sample;

   logic signed [SUM_W-1:0] sum_ff;
   logic [SQSUM_W-1:0]      sumsq_ff;
   logic signed [SQ_W-1:0]  sq_new, sq_old;
   logic [SQ_W-1:0]         sq_new_ff, sq_old_ff;

   logic [PROD_W-1:0]        prod, prod_ff;
   logic signed [SUMSQ_W-1:0] sum_sq;
   logic [SUMSQ_W-1:0]       sum_sq_ff;
   logic [2*LEN_W-1:0]       den_full;
   logic [DEN_W-1:0]         den_ff;
   logic [PROD_W:0]          diff;
   logic [PROD_W-1:0]        num;

   logic [SUM_W-1:0] sum_mag;
   logic             mean_neg_ff;
   logic             mean_start, mean_busy;
   logic [MQ_W-1:0]  mean_q, mean_val;
   logic             var_start, var_busy;
   logic [VQ_W-1:0]  var_q;
   logic             root_start, root_busy;
   logic [RT_W-1:0]  root;

   logic              rsp_valid_ff;
   logic              out_free;
   logic [OUT_W-1:0]  mean_fix_ff;
   logic [OUT_W-1:0]  stddev_fix_ff;
   logic [SLOT_W-1:0] slot_ff;

   rwms_store_cmd_type store_cmd;

   // ring position and window length
   assign accept    = req_bus.valid && req_bus.ready;
   assign pos       = (LEN_W'(wpos_ff) >= len_ff) ? '0 : wpos_ff;
   assign wpos_next = (LEN_W'(pos) + 1'b1 == len_ff) ? '0 : pos + 1'b1;

   always_comb begin
      if (csr_wdata < LEN_MIN) begin
         len_in = LEN_MIN;
      end else if (csr_wdata > LEN_MAX) begin
         len_in = LEN_MAX;
      end else begin
         len_in = csr_wdata;
      end
   end

   assign store_cmd.clear = csr_we;
   assign store_cmd.write = accept;
   assign store_cmd.addr  = pos;

   rwms_store u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .wr_data (req_bus.sample),
      .rd_data (old_sample)
   );

   // datapath products, variance numerator and mean magnitude
   assign sq_new   = sample_ff * sample_ff;
   assign sq_old   = old_sample * old_sample;
   assign prod     = len_ff * sumsq_ff;
   assign sum_sq   = sum_ff * sum_ff;
   assign den_full = len_ff * (len_ff - LEN_W'(1));
   assign diff     = (PROD_W+1)'(prod_ff) - (PROD_W+1)'(sum_sq_ff);
   assign num      = diff[PROD_W] ? '0 : diff[PROD_W-1:0];
   assign sum_mag  = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;

   assign mean_start = (state_ff == ST_UPD2);
   assign var_start  = (state_ff == ST_SUB);
   assign root_start = (state_ff == ST_DIV) && !var_busy && !mean_busy;

   rwms_div #(
      .DVS_W     (LEN_W),
      .Q_W       (MQ_W),
      .STEP_BITS (DIV_STEP)
   ) u_mean_div (
      .clock       (clock),
      .reset       (reset),
      .start       (mean_start),
      .rem_init    ('0),
      .dividend_lo ({sum_mag, {FRAC_W{1'b0}}}),
      .divisor     (len_ff),
      .busy        (mean_busy),
      .quotient    (mean_q)
   );

   // num * 2^(2*FRAC_W) / den; the top part is already below den
   rwms_div #(
      .DVS_W     (DEN_W),
      .Q_W       (VQ_W),
      .STEP_BITS (DIV_STEP)
   ) u_var_div (
      .clock       (clock),
      .reset       (reset),
      .start       (var_start),
      .rem_init    (num[VSPLIT +: DEN_W]),
      .dividend_lo ({num[VSPLIT-1:0], {(2*FRAC_W){1'b0}}}),
      .divisor     (den_ff),
      .busy        (var_busy),
      .quotient    (var_q)
   );

   rwms_isqrt #(
      .RT_W (RT_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (var_q),
      .busy     (root_busy),
      .root     (root)
   );

   assign mean_val = mean_neg_ff ? (~mean_q + 1'b1) : mean_q;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPD1;
            end
         end
         ST_UPD1: state_in = ST_UPD2;
         ST_UPD2: state_in = ST_MUL;
         ST_MUL:  state_in = ST_SUB;
         ST_SUB:  state_in = ST_DIV;
         ST_DIV: begin
            if (root_start) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (!root_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_RESET;
         wpos_ff      <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            len_ff   <= len_in;
            wpos_ff  <= '0;
            sum_ff   <= '0;
            sumsq_ff <= '0;
         end else begin
            if (accept) begin
               wpos_ff <= wpos_next;
            end
            if (state_ff == ST_UPD1) begin
               sum_ff <= sum_ff + SUM_W'(sample_ff) - SUM_W'(old_sample);
            end
            if (state_ff == ST_UPD2) begin
               sumsq_ff <= sumsq_ff + SQSUM_W'(sq_new_ff) - SQSUM_W'(sq_old_ff);
            end
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_bus.sample;
         pos_ff    <= pos;
      end
      if (state_ff == ST_UPD1) begin
         sq_new_ff <= $unsigned(sq_new);
         sq_old_ff <= $unsigned(sq_old);
      end
      if (state_ff == ST_UPD2) begin
         mean_neg_ff <= sum_ff[SUM_W-1];
      end
      if (state_ff == ST_MUL) begin
         prod_ff   <= prod;
         sum_sq_ff <= $unsigned(sum_sq);
         den_ff    <= den_full[DEN_W-1:0];
      end
      if (state_ff == ST_OUT && out_free) begin
         mean_fix_ff   <= mean_val[OUT_W-1:0];
         stddev_fix_ff <= root;
         slot_ff       <= SLOT_W'(pos_ff);
      end
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mean_fix     = mean_fix_ff;
   assign rsp_bus.stddev_fix   = stddev_fix_ff;
   assign rsp_bus.slot_written = slot_ff;

endmodule

>>> src/rwms_checker.sv
// port-level checks of the moving window statistics block, bound to the top level
// depends on rwms_pkg and ring_window_mean_stddev_defines.svh
`include "ring_window_mean_stddev_defines.svh"

module rwms_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [rwms_pkg::OUT_W-1:0]  rsp_mean_fix,
   input logic [rwms_pkg::OUT_W-1:0]  rsp_stddev_fix,
   input logic [rwms_pkg::SLOT_W-1:0] rsp_slot_written
);

   // one word at a time: ready stays low through the sum update states after an accept
   `RWMS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready ##1 !req_ready, "request accepted while a word is still in work")

   // a fresh response only comes out of a busy sequencer
   `RWMS_ASSERT_IMP(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready), "response appeared while the block was idle")

   `RWMS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_mean_fix) && $stable(rsp_stddev_fix) && $stable(rsp_slot_written), "stalled response word changed")

endmodule

bind ring_window_mean_stddev rwms_checker u_rwms_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_mean_fix     (rsp_bus.mean_fix),
   .rsp_stddev_fix   (rsp_bus.stddev_fix),
   .rsp_slot_written (rsp_bus.slot_written)
);
